/* rtl/tgrf_pkg.sv */
// ----------------------------------------------------------------------------
// tgrf_pkg - shared types and constants of the task ready-frontier scoreboard
// Word layouts, mode codes and the command/status bundle between controller
// and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tgrf_pkg;

	localparam int MAX_TASKS_DEF  = 32;
	localparam int MAX_SLICES_DEF = 16;

	localparam int MODE_W  = 3;
	localparam int ID_W    = 5;
	localparam int SLICE_W = 4;
	localparam int MASK_W  = 16;

	localparam logic [MODE_W-1:0] MODE_ADD_TASK = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADD_EDGE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_COMPLETE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FRONTIER = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PARENTS  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CHILDREN = 3'd5;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [ID_W-1:0]    task_id;
		logic [ID_W-1:0]    other_task;
		logic [SLICE_W-1:0] slice_id;
		logic [MASK_W-1:0]  visible_mask;
	} in_word_t;

	typedef struct packed {
		logic [ID_W-1:0] out_task;
		logic            item_valid;
		logic            last;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic update;   // apply an update word this cycle
		logic capture;  // latch a query word, rewind the scan
		logic step;     // evaluate one entry of the scan
		logic flush;    // close the list
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_end; // entry under evaluation is the final one
	} ctrl_sts_t;

endpackage

`default_nettype wire

/* rtl/tgrf_ctrl.sv */
// ----------------------------------------------------------------------------
// tgrf_ctrl - sequencing FSM of the scoreboard
// Takes words, fires updates at once, walks queries through scan and flush.
// ----------------------------------------------------------------------------
`default_nettype none

module tgrf_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [2:0]         mode,
	input  wire tgrf_pkg::ctrl_sts_t sts,
	output tgrf_pkg::ctrl_cmd_t     cmd,
	output logic                    busy
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (mode) inside
						tgrf_pkg::MODE_ADD_TASK, tgrf_pkg::MODE_ADD_EDGE,
						tgrf_pkg::MODE_COMPLETE: begin
							cmd.update = 1'b1;
						end
						tgrf_pkg::MODE_FRONTIER, tgrf_pkg::MODE_PARENTS,
						tgrf_pkg::MODE_CHILDREN: begin
							cmd.capture = 1'b1;
							state_d     = ST_SCAN;
						end
						default: begin
							// spare codes: word taken, nothing done
						end
					endcase
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (sts.scan_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/tgrf_dp.sv */
// ----------------------------------------------------------------------------
// tgrf_dp - scoreboard state and scan datapath
// Holds presence, completion, slice tags and the parent matrix; evaluates one
// task per scan step and registers the list words with a one-deep hold-back
// so the final element can carry its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tgrf_dp #(
	parameter int MAX_TASKS  = tgrf_pkg::MAX_TASKS_DEF,
	parameter int MAX_SLICES = tgrf_pkg::MAX_SLICES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tgrf_pkg::in_word_t  item,
	input  wire tgrf_pkg::ctrl_cmd_t cmd,
	output tgrf_pkg::ctrl_sts_t      sts,
	output logic                     result_valid,
	output tgrf_pkg::out_word_t      result
);

	// ids are 5 bits wide, so at most 32 entries are reachable
	localparam int SPAN  = (MAX_TASKS < 32) ? MAX_TASKS : 32;
	localparam int IDX_W = (SPAN > 1) ? $clog2(SPAN) : 1;

	logic [SPAN-1:0]                  present_q;
	logic [SPAN-1:0]                  done_q;
	logic [tgrf_pkg::SLICE_W-1:0]     slice_q [SPAN];
	logic [SPAN-1:0]                  row_q   [SPAN];

	// query context
	logic [tgrf_pkg::MODE_W-1:0]      qmode_q;
	logic [tgrf_pkg::MASK_W-1:0]      qmask_q;
	logic [IDX_W-1:0]                 qidx_q;
	logic                             qok_q;
	logic [SPAN-1:0]                  qrow_q;
	logic [IDX_W-1:0]                 cnt_q;

	// hold-back element
	logic                             pend_q;
	logic [IDX_W-1:0]                 pend_id_q;

	logic                             res_valid_q;
	tgrf_pkg::out_word_t              res_q;

	logic                             t_ok;
	logic                             o_ok;
	logic                             s_ok;
	logic [IDX_W-1:0]                 t_idx;
	logic [IDX_W-1:0]                 o_idx;
	logic [SPAN-1:0]                  row_i;
	logic                             vis;
	logic                             front_hit;
	logic                             hit;

	assign t_ok  = 32'(item.task_id) < SPAN;
	assign o_ok  = 32'(item.other_task) < SPAN;
	assign s_ok  = 32'(item.slice_id) < MAX_SLICES;
	assign t_idx = item.task_id[IDX_W-1:0];
	assign o_idx = item.other_task[IDX_W-1:0];

	assign sts.scan_end = (cnt_q == IDX_W'(SPAN - 1));

	// per-entry evaluation
	assign row_i     = row_q[cnt_q];
	assign vis       = (qmask_q == '0) || qmask_q[slice_q[cnt_q]];
	assign front_hit = present_q[cnt_q] && !done_q[cnt_q] && vis
	                   && ((row_i & ~done_q) == '0);

	always_comb begin
		case (qmode_q)
			tgrf_pkg::MODE_FRONTIER: hit = front_hit;
			tgrf_pkg::MODE_PARENTS:  hit = qrow_q[cnt_q];
			tgrf_pkg::MODE_CHILDREN: hit = qok_q && row_i[qidx_q];
			default:                 hit = 1'b0;
		endcase
	end

	// scoreboard state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			done_q    <= '0;
			for (int i = 0; i < SPAN; i++) begin
				row_q[i] <= '0;
			end
		end else if (cmd.update) begin
			unique case (item.mode)
				tgrf_pkg::MODE_ADD_TASK: begin
					if (t_ok && s_ok) begin
						present_q[t_idx] <= 1'b1;
					end
				end
				tgrf_pkg::MODE_ADD_EDGE: begin
					if (t_ok && o_ok) begin
						row_q[o_idx][t_idx] <= 1'b1;
					end
				end
				tgrf_pkg::MODE_COMPLETE: begin
					if (t_ok) begin
						done_q[t_idx] <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// slice tags: only read for present tasks
	always_ff @(posedge clk) begin
		if (cmd.update && item.mode == tgrf_pkg::MODE_ADD_TASK && t_ok && s_ok) begin
			slice_q[t_idx] <= item.slice_id;
		end
	end

	// query context
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			qmode_q <= item.mode;
			qmask_q <= item.visible_mask;
			qidx_q  <= t_idx;
			qok_q   <= t_ok;
			qrow_q  <= t_ok ? row_q[t_idx] : '0;
		end
	end

	// scan counter, hold-back and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// a word leaves on the flush, or when a later hit displaces the held one
			res_valid_q <= cmd.flush || (cmd.step && hit && pend_q);
			if (cmd.capture) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.capture || cmd.flush) begin
				pend_q <= 1'b0;
			end else if (cmd.step && hit) begin
				pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && hit) begin
			pend_id_q        <= cnt_q;
			res_q.out_task   <= tgrf_pkg::ID_W'(pend_id_q);
			res_q.item_valid <= 1'b1;
			res_q.last       <= 1'b0;
		end
		if (cmd.flush) begin
			res_q.out_task   <= pend_q ? tgrf_pkg::ID_W'(pend_id_q) : '0;
			res_q.item_valid <= pend_q;
			res_q.last       <= 1'b1;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_res_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> $past(cmd.step || cmd.flush))
		else $error("result word without scan activity");

	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.item_valid) |-> (res_q.last && res_q.out_task == '0))
		else $error("malformed empty-list marker");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (res_valid_q && res_q.last && !pend_q))
		else $error("flush did not close the list");

	a_capture_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (cnt_q == '0 && !pend_q))
		else $error("scan not rewound on capture");

endmodule

`default_nettype wire

/* rtl/task_graph_ready_frontier.sv */
// ----------------------------------------------------------------------------
// task_graph_ready_frontier - task dependency scoreboard
// Tracks tasks, slice tags, completion and parent->child edges; answers
// ready-frontier, parent-list and child-list queries as id-ordered lists.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | word
//  ----------+------------------------+---------------------------------------
//  input     | start & !busy          | item   (mode, task_id, other_task,
//            |                        |         slice_id, visible_mask)
//  result    | result_valid, 1 cycle  | result (out_task, item_valid, last)
//
// Update words (add task, add edge, complete, spare codes) leave busy low.
// A query holds busy through a scan of min(MAX_TASKS,32) entries, one matrix
// row per cycle, and then through the flush state.
// Each hit is held back until the next hit or the flush, so a list word can
// trail its scan step by up to a whole scan; the closing word is on the port
// in the first cycle with busy low, and the next word may be taken then.
// Reset clears presence, completion and the whole parent matrix at once.
// The result side has no back-pressure: each word is valid for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module task_graph_ready_frontier #(
	parameter int MAX_TASKS  = tgrf_pkg::MAX_TASKS_DEF,
	parameter int MAX_SLICES = tgrf_pkg::MAX_SLICES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire tgrf_pkg::in_word_t item,
	output logic                    result_valid,
	output tgrf_pkg::out_word_t     result
);

	tgrf_pkg::ctrl_cmd_t cmd;
	tgrf_pkg::ctrl_sts_t sts;

	// sequencing: decides update vs. query and paces the scan
	tgrf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (item.mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// state store, per-entry evaluation and list output
	tgrf_dp #(
		.MAX_TASKS  (MAX_TASKS),
		.MAX_SLICES (MAX_SLICES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire
